[design/zone_irrigation_sequencer_assert.svh]
// Assertion macros used by the zone irrigation sequencer state module (zis_seq).
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef ZONE_IRRIGATION_SEQUENCER_ASSERT_SVH
`define ZONE_IRRIGATION_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ZIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone irrigation sequencer: assertion failed");
// Next-cycle implication, checked outside reset.
`define ZIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zone irrigation sequencer: assertion failed");
`else
`define ZIS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ZIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/zis_pkg.sv]
// Package for the zone irrigation sequencer: transaction types, codes and the time ladder.
// No dependencies.
`default_nettype none

package zis_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_SETTLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_MASK = 2'd3;

    localparam logic [23:0] ON_SETTLE_RST  = 24'd192;
    localparam logic [23:0] OFF_SETTLE_RST = 24'd192;
    localparam logic [23:0] TICKS_MIN_RST  = 24'd3840;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_BUTTON  = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_SET     = 3'd5;

    localparam logic [2:0] ST_UI       = 3'd0;
    localparam logic [2:0] ST_WAIT_ON  = 3'd1;
    localparam logic [2:0] ST_ON       = 3'd2;
    localparam logic [2:0] ST_WAIT_OFF = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;

    localparam logic [3:0] NO_ZONE = 4'd8;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] zone;
        logic [7:0] minutes;
    } t_in_item;

    typedef struct packed {
        logic [7:0] relay_mask;
        logic [2:0] run_state;
        logic [3:0] current_zone;
        logic [7:0] shown_minutes;
        logic       display_overflow;
        logic [7:0] leds_on;
        logic [7:0] leds_blink;
        logic       dot_blink;
        logic       modified;
    } t_out_item;

    // Sequencer status handed to the display formatter.
    typedef struct packed {
        logic [2:0] state;
        logic [3:0] sel;
        logic [7:0] relays;
        logic       changed;
    } t_seq_status;

    // One step along the button ladder 1,2,3,4,5,7,10,13,16,20,25,30,0.
    function automatic logic [7:0] next_rung(input logic [7:0] v);
        logic [7:0] r;
        if (v < 8'd5) begin
            r = v + 8'd1;
        end else if (v < 8'd7) begin
            r = v + 8'd2;
        end else if (v < 8'd16) begin
            r = v + 8'd3;
        end else if (v < 8'd20) begin
            r = v + 8'd4;
        end else if (v < 8'd30) begin
            r = v + 8'd5;
        end else begin
            r = 8'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/zis_seq.sv]
// Sequencer state, configuration registers and the per-transaction state update.
// Depends on zis_pkg and zone_irrigation_sequencer_assert.svh.
`default_nettype none
`include "zone_irrigation_sequencer_assert.svh"

module zis_seq #(
    parameter int ZONES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [zis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [zis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_go,
    input  wire zis_pkg::t_in_item             i_item,
    output zis_pkg::t_seq_status               o_status,
    output logic [7:0]                         o_minutes [ZONES]
);
    import zis_pkg::*;

    logic [23:0] r_on_settle;
    logic [23:0] r_off_settle;
    logic [23:0] r_tpm;
    logic [63:0] r_masks;

    logic [7:0]  r_minutes [ZONES];
    logic [7:0]  n_minutes [ZONES];
    logic [2:0]  r_state, n_state;
    logic [3:0]  r_sel, n_sel;
    logic [31:0] r_st_ticks, n_st_ticks;
    logic [31:0] r_mt_ticks, n_mt_ticks;
    logic [31:0] r_on_dur, n_on_dur;
    logic [7:0]  r_relays, n_relays;
    logic        r_changed, n_changed;

    logic        sel_valid;
    logic        zone_ok;
    logic [7:0]  cur_min;
    logic [7:0]  zone_min;
    logic [7:0]  sel_mask;
    logic        found_after;
    logic [3:0]  idx_after;
    logic        found_any;
    logic [3:0]  idx_any;
    logic [31:0] st_inc;
    logic [31:0] mt_inc;
    logic [31:0] dur_product;

    // Selection and search over the zones.
    always_comb begin
        cur_min     = 8'd0;
        zone_min    = 8'd0;
        sel_mask    = 8'd0;
        found_after = 1'b0;
        idx_after   = NO_ZONE;
        found_any   = 1'b0;
        idx_any     = NO_ZONE;
        for (int i = 0; i < ZONES; i++) begin
            if (4'(i) == r_sel) begin
                cur_min  = r_minutes[i];
                sel_mask = r_masks[8*i +: 8];
            end
            if (3'(i) == i_item.zone) begin
                zone_min = r_minutes[i];
            end
        end
        // Downward scan so that the lowest qualifying zone wins.
        for (int i = ZONES - 1; i >= 0; i--) begin
            if (r_minutes[i] != 8'd0) begin
                found_any = 1'b1;
                idx_any   = 4'(i);
                if (4'(i) > r_sel) begin
                    found_after = 1'b1;
                    idx_after   = 4'(i);
                end
            end
        end
    end

    assign sel_valid   = r_sel < 4'(ZONES);
    assign zone_ok     = {1'b0, i_item.zone} < 4'(ZONES);
    assign st_inc      = (r_st_ticks == '1) ? r_st_ticks : r_st_ticks + 32'd1;
    assign mt_inc      = (r_mt_ticks == '1) ? r_mt_ticks : r_mt_ticks + 32'd1;
    assign dur_product = {24'd0, cur_min} * {8'd0, r_tpm};

    always_comb begin
        n_minutes  = r_minutes;
        n_state    = r_state;
        n_sel      = r_sel;
        n_st_ticks = r_st_ticks;
        n_mt_ticks = r_mt_ticks;
        n_on_dur   = r_on_dur;
        n_relays   = r_relays;
        n_changed  = r_changed;

        unique case (i_item.opcode)
            OP_TICK: begin
                n_st_ticks = st_inc;
                n_mt_ticks = mt_inc;
                if (sel_valid) begin
                    unique case (r_state)
                        ST_WAIT_ON: begin
                            if (st_inc > {8'd0, r_on_settle}) begin
                                n_relays   = (sel_mask != 8'd0) ? sel_mask
                                                                : (8'd1 << r_sel[2:0]);
                                n_on_dur   = dur_product;
                                n_state    = ST_ON;
                                n_st_ticks = 32'd0;
                                n_mt_ticks = 32'd0;
                            end
                        end
                        ST_ON: begin
                            if (st_inc > r_on_dur) begin
                                n_relays   = 8'd0;
                                n_state    = ST_WAIT_OFF;
                                n_st_ticks = 32'd0;
                                for (int i = 0; i < ZONES; i++) begin
                                    if (4'(i) == r_sel) begin
                                        n_minutes[i] = 8'd0;
                                    end
                                end
                            end else if (mt_inc > {8'd0, r_tpm}) begin
                                n_mt_ticks = mt_inc - {8'd0, r_tpm};
                                for (int i = 0; i < ZONES; i++) begin
                                    if (4'(i) == r_sel && cur_min != 8'd0) begin
                                        n_minutes[i] = cur_min - 8'd1;
                                    end
                                end
                            end
                        end
                        ST_WAIT_OFF: begin
                            if (st_inc > {8'd0, r_off_settle}) begin
                                n_st_ticks = 32'd0;
                                if (found_after) begin
                                    n_sel   = idx_after;
                                    n_state = ST_WAIT_ON;
                                end else begin
                                    n_sel   = NO_ZONE;
                                    n_state = ST_FINISHED;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_BUTTON: begin
                if (zone_ok) begin
                    n_state = ST_UI;
                    if ({1'b0, i_item.zone} != r_sel) begin
                        n_sel = {1'b0, i_item.zone};
                        if (zone_min == 8'd0) begin
                            n_changed = 1'b1;
                        end
                    end else begin
                        n_changed = 1'b1;
                    end
                    for (int i = 0; i < ZONES; i++) begin
                        if (3'(i) == i_item.zone) begin
                            if ({1'b0, i_item.zone} != r_sel) begin
                                if (zone_min == 8'd0) begin
                                    n_minutes[i] = 8'd1;
                                end
                            end else begin
                                n_minutes[i] = next_rung(zone_min);
                            end
                        end
                    end
                end
            end
            OP_RESTART: begin
                if (zone_ok) begin
                    n_changed = 1'b0;
                    n_relays  = 8'd0;
                    n_state   = ST_UI;
                    if (found_any) begin
                        n_sel = idx_any;
                    end else begin
                        // No zone programmed: the addressed zone gets one minute.
                        n_sel = {1'b0, i_item.zone};
                        for (int i = 0; i < ZONES; i++) begin
                            if (3'(i) == i_item.zone) begin
                                n_minutes[i] = 8'd1;
                            end
                        end
                    end
                end
            end
            OP_START: begin
                n_st_ticks = 32'd0;
                if (found_any) begin
                    n_sel   = idx_any;
                    n_state = ST_WAIT_ON;
                end else begin
                    n_sel   = NO_ZONE;
                    n_state = ST_FINISHED;
                end
            end
            OP_STOP: begin
                n_state = ST_FINISHED;
                n_sel   = NO_ZONE;
            end
            OP_SET: begin
                if (zone_ok) begin
                    for (int i = 0; i < ZONES; i++) begin
                        if (3'(i) == i_item.zone) begin
                            n_minutes[i] = i_item.minutes;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_settle  <= ON_SETTLE_RST;
            r_off_settle <= OFF_SETTLE_RST;
            r_tpm        <= TICKS_MIN_RST;
            r_masks      <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ON_SETTLE:  r_on_settle  <= i_cfg_data[23:0];
                CFG_OFF_SETTLE: r_off_settle <= i_cfg_data[23:0];
                CFG_TICKS_MIN:  r_tpm        <= i_cfg_data[23:0];
                CFG_RELAY_MASK: r_masks      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ZONES; i++) begin
                r_minutes[i] <= 8'd0;
            end
            r_state    <= ST_FINISHED;
            r_sel      <= NO_ZONE;
            r_st_ticks <= 32'd0;
            r_mt_ticks <= 32'd0;
            r_on_dur   <= 32'd0;
            r_relays   <= 8'd0;
            r_changed  <= 1'b0;
        end else if (i_go) begin
            r_minutes  <= n_minutes;
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_st_ticks <= n_st_ticks;
            r_mt_ticks <= n_mt_ticks;
            r_on_dur   <= n_on_dur;
            r_relays   <= n_relays;
            r_changed  <= n_changed;
        end
    end

    // The result shows the state after the transaction has been applied.
    assign o_status.state   = n_state;
    assign o_status.sel     = n_sel;
    assign o_status.relays  = n_relays;
    assign o_status.changed = n_changed;
    assign o_minutes        = n_minutes;

    `ZIS_ASSERT_IMP(a_on_drives_relays, i_clk, i_rst_n, r_state == ST_ON, r_relays != 8'd0)
    `ZIS_ASSERT_IMP(a_finished_no_zone, i_clk, i_rst_n, r_state == ST_FINISHED, r_sel == NO_ZONE)
    `ZIS_ASSERT_IMP(a_active_has_zone, i_clk, i_rst_n, r_state != ST_FINISHED, r_sel < 4'(ZONES))
    `ZIS_ASSERT_NEXT(a_stop_ends_run, i_clk, i_rst_n, i_go && i_item.opcode == OP_STOP, r_state == ST_FINISHED && r_sel == NO_ZONE)

endmodule

`default_nettype wire

[design/zis_view.sv]
// Display and LED formatting of the sequencer status into a result transaction.
// Depends on zis_pkg.
`default_nettype none

module zis_view #(
    parameter int ZONES = 8
) (
    input  wire zis_pkg::t_seq_status i_status,
    input  wire logic [7:0]           i_minutes [ZONES],
    output zis_pkg::t_out_item        o_item
);
    import zis_pkg::*;

    logic [7:0] shown;
    logic [7:0] lon;
    logic [7:0] lblink;
    logic       active;

    assign active = i_status.state != ST_FINISHED;

    always_comb begin
        shown  = 8'd0;
        lon    = 8'd0;
        lblink = 8'd0;
        if (active) begin
            for (int i = 0; i < ZONES; i++) begin
                if (4'(i) == i_status.sel) begin
                    lblink[i] = 1'b1;
                    shown     = i_minutes[i];
                end else if (i_minutes[i] != 8'd0) begin
                    lon[i] = 1'b1;
                end
            end
        end
    end

    assign o_item.relay_mask       = i_status.relays;
    assign o_item.run_state        = i_status.state;
    assign o_item.current_zone     = i_status.sel;
    assign o_item.shown_minutes    = shown;
    assign o_item.display_overflow = shown > 8'd99;
    assign o_item.leds_on          = lon;
    assign o_item.leds_blink       = lblink;
    assign o_item.dot_blink        = i_status.state == ST_ON;
    assign o_item.modified         = i_status.changed;

endmodule

`default_nettype wire

[design/zone_irrigation_sequencer.sv]
// Zone irrigation sequencer top level: input register, state update, result register.
// The result is formed from the input register and captured in the result register.
// One transaction per cycle unless the output stalls; the input register frees whenever
// the result register is empty or being taken, so both sides can stream without gaps.
// Synchronous active-low reset clears all zone times, selects no zone and enters finished.
// Depends on zis_pkg, zis_seq and zis_view.
`default_nettype none

module zone_irrigation_sequencer #(
    parameter int ZONES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire zis_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output zis_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [zis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [zis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import zis_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        advance;
    t_seq_status status;
    logic [7:0]  minutes [ZONES];
    t_out_item   result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    zis_seq #(
        .ZONES(ZONES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_go       (advance),
        .i_item     (r_in),
        .o_status   (status),
        .o_minutes  (minutes)
    );

    zis_view #(
        .ZONES(ZONES)
    ) u_view (
        .i_status (status),
        .i_minutes(minutes),
        .o_item   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
